// ===== sv/mflg_pkg.sv =====
// mflg_pkg: shared types and constants of the max-flow level-graph block
// field widths, register indexes, reset values and the sequencer state type
// no dependencies
`default_nettype none

package mflg_pkg;

    localparam int ID_W   = 6;
    localparam int CAP_W  = 16;
    localparam int FLOW_W = 26;
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 6;

    localparam logic [CFG_AW-1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_SOURCE     = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_SINK       = 2'd2;

    localparam logic [ID_W-1:0] NODE_COUNT_RST = 6'd60;
    localparam logic [ID_W-1:0] SOURCE_RST     = 6'd1;
    localparam logic [ID_W-1:0] SINK_RST       = 6'd26;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_INS1,
        ST_INS2,
        ST_START,
        ST_SWEEP,
        ST_BFS_POP,
        ST_BFS_U,
        ST_BFS_U2,
        ST_BFS_ARC,
        ST_BFS_V,
        ST_BFS_CHK,
        ST_BFS_END,
        ST_DFS_TOP,
        ST_DFS_LD,
        ST_DFS_ARC,
        ST_DFS_V,
        ST_DFS_CHK,
        ST_DFS_RET,
        ST_PAR_S,
        ST_PAR_T,
        ST_AUG_RD,
        ST_AUG_S,
        ST_AUG_M,
        ST_UPD_RD,
        ST_UPD_S,
        ST_UPD_W,
        ST_FINISH,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== sv/max_flow_level_graph.sv =====
// max_flow_level_graph: edge loader and level-graph maximum-flow engine
// depends on mflg_pkg (types, constants, state type)
// all memories are local arrays with registered reads
//
// usage:
//   edges arrive on the s_ channel, one transfer each: s_tdata holds from, to and
//   capacity, s_tlast marks the final edge of a graph.  loading an edge runs a head
//   read, an arc-pair write and a second head write; s_tready is low for the writes.
//   an edge with a node of zero or not below MAX_NODES is ignored; an edge that finds
//   the arc store full is dropped and sets the drop flag.
//   after the final edge the engine runs rounds of breadth-first levels and a
//   stack-based blocking-flow search, one memory step per cycle on a single arc
//   port.  a round sweeps every node and then spends its steps per arc visited and
//   per path node augmented, so the latency grows with graph size.
//   the result (flow and drop flag) is held on the m_ channel until the receiver
//   takes it; no new edge is accepted until that transfer.  the edge store is
//   emptied when the result is formed.
//   reset (aresetn low, synchronous) empties the store, clears the flag and loads
//   the register defaults.  configuration writes are taken at any time, but are
//   meant to be issued only while no graph is being processed.
`default_nettype none

module max_flow_level_graph #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [mflg_pkg::CFG_AW-1:0] cfg_addr,
    input  wire logic [mflg_pkg::CFG_DW-1:0] cfg_wdata,
    // edge input: from_node [5:0], to_node [11:6], capacity [27:12], zero pad
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        s_tlast,   // last_edge
    // result: total_flow [25:0], edges_dropped [26], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata
);

    localparam int NIDX = $clog2(MAX_NODES);
    localparam int KW   = $clog2(MAX_EDGES);
    localparam int LW   = NIDX + 1;
    localparam int ID_W = mflg_pkg::ID_W;
    localparam int CW   = mflg_pkg::CAP_W;
    localparam int FW   = mflg_pkg::FLOW_W;

    // arc pointer: nil flag, pair index, side (0 forward, 1 reverse)
    typedef logic [KW+1:0] ptr_t;
    typedef logic [KW:0]   arc_t;
    localparam ptr_t PTR_NIL = {1'b1, {(KW+1){1'b0}}};
    localparam logic [LW-1:0] NO_LVL = {LW{1'b1}};

    typedef struct packed {
        logic [ID_W-1:0] tgt_f;
        logic [ID_W-1:0] tgt_r;
        ptr_t            link_f;
        ptr_t            link_r;
        logic [CW-1:0]   res_f;
        logic [CW-1:0]   res_r;
    } pair_t;

    // control registers
    mflg_pkg::state_t state_reg, state_next;
    logic [ID_W-1:0] node_count_reg, src_reg, snk_reg;
    logic [KW:0]     pcnt_reg, pcnt_next;
    logic            ovf_reg, ovf_next;
    logic [MAX_NODES-1:0] head_vld_reg, head_vld_next;

    // working registers
    logic [ID_W-1:0] eu_reg, eu_next, ev_reg, ev_next;
    logic [CW-1:0]   ecap_reg, ecap_next;
    logic            elast_reg, elast_next;
    logic [FW-1:0]   flow_reg, flow_next;
    logic [NIDX:0]   idx_reg, idx_next, qh_reg, qh_next, qt_reg, qt_next;
    logic [NIDX:0]   depth_reg, depth_next, k_reg, k_next, kz_reg, kz_next;
    logic            kz_found_reg, kz_found_next, res_nz_reg, res_nz_next;
    logic [ID_W-1:0] u_reg, u_next, v_reg, v_next;
    logic [LW-1:0]   lvl_u_reg, lvl_u_next;
    ptr_t            arc_reg, arc_next, link_reg, link_next;
    logic [CW-1:0]   b_reg, b_next;
    logic [FW-1:0]   m_flow_reg, m_flow_next;
    logic            m_drop_reg, m_drop_next;

    // memories and their ports
    arc_t            head_mem  [MAX_NODES];
    pair_t           pair_mem  [MAX_EDGES];
    logic [LW-1:0]   level_mem [MAX_NODES];
    ptr_t            resume_mem[MAX_NODES];
    logic [ID_W-1:0] queue_mem [MAX_NODES];
    arc_t            stack_mem [MAX_NODES];

    logic [NIDX-1:0] head_ra, head_rb, head_wa;
    logic            head_we;
    arc_t            head_wd;
    ptr_t            head_qa_reg, head_qb_reg;
    logic [KW-1:0]   pair_ra, pair_wa;
    logic            pair_we;
    pair_t           pair_wd, pair_q_reg;
    logic [NIDX-1:0] level_ra, level_wa;
    logic            level_we;
    logic [LW-1:0]   level_wd, level_q_reg;
    logic [NIDX-1:0] resume_ra, resume_wa;
    logic            resume_we;
    ptr_t            resume_wd, resume_q_reg;
    logic [NIDX-1:0] queue_ra, queue_wa;
    logic            queue_we;
    logic [ID_W-1:0] queue_wd, queue_q_reg;
    logic [NIDX-1:0] stack_ra, stack_wa;
    logic            stack_we;
    arc_t            stack_wd, stack_q_reg;

    // decoded input fields
    logic [ID_W-1:0] in_from, in_to;
    logic [CW-1:0]   in_cap;
    logic            in_ok, s_xfer;

    // side-selected view of the pair word read for arc_reg
    logic [ID_W-1:0] p_tgt;
    logic [CW-1:0]   p_res;
    ptr_t            p_link;
    pair_t           p_upd;
    logic [FW:0]     flow_sum;
    logic [NIDX:0]   depth_dec;
    logic [LW:0]     lvl_inc;

    function automatic logic node_ok(input logic [ID_W-1:0] n, input logic [ID_W-1:0] cnt);
        return (n != '0) && (n <= cnt) && ({26'd0, n} < MAX_NODES);
    endfunction

    function automatic logic [NIDX-1:0] nidx(input logic [ID_W-1:0] n);
        return NIDX'(n);
    endfunction

    assign in_from = s_tdata[5:0];
    assign in_to   = s_tdata[11:6];
    assign in_cap  = s_tdata[27:12];
    assign in_ok   = (in_from != '0) && (in_to != '0) &&
                     ({26'd0, in_from} < MAX_NODES) && ({26'd0, in_to} < MAX_NODES);
    assign s_xfer  = s_tvalid && s_tready;

    assign s_tready = (state_reg == mflg_pkg::ST_LOAD);
    assign m_tvalid = (state_reg == mflg_pkg::ST_OUT);
    assign m_tdata  = {5'd0, m_drop_reg, m_flow_reg};

    assign p_tgt  = arc_reg[0] ? pair_q_reg.tgt_r  : pair_q_reg.tgt_f;
    assign p_res  = arc_reg[0] ? pair_q_reg.res_r  : pair_q_reg.res_f;
    assign p_link = arc_reg[0] ? pair_q_reg.link_r : pair_q_reg.link_f;
    assign flow_sum  = {1'b0, flow_reg} + (FW+1)'(b_reg);
    assign depth_dec = depth_reg - 1'b1;
    assign lvl_inc   = {1'b0, lvl_u_reg} + 1'b1;

    // augmented pair: chosen side loses the bottleneck, its twin gains it
    always_comb begin
        p_upd = pair_q_reg;
        if (arc_reg[0]) begin
            p_upd.res_r = pair_q_reg.res_r - b_reg;
            p_upd.res_f = pair_q_reg.res_f + b_reg;
        end else begin
            p_upd.res_f = pair_q_reg.res_f - b_reg;
            p_upd.res_r = pair_q_reg.res_r + b_reg;
        end
    end

    // sequencer: next state, datapath updates and memory port control
    always_comb begin
        state_next    = state_reg;
        pcnt_next     = pcnt_reg;
        ovf_next      = ovf_reg;
        head_vld_next = head_vld_reg;
        eu_next       = eu_reg;
        ev_next       = ev_reg;
        ecap_next     = ecap_reg;
        elast_next    = elast_reg;
        flow_next     = flow_reg;
        idx_next      = idx_reg;
        qh_next       = qh_reg;
        qt_next       = qt_reg;
        depth_next    = depth_reg;
        k_next        = k_reg;
        kz_next       = kz_reg;
        kz_found_next = kz_found_reg;
        res_nz_next   = res_nz_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        lvl_u_next    = lvl_u_reg;
        arc_next      = arc_reg;
        link_next     = link_reg;
        b_next        = b_reg;
        m_flow_next   = m_flow_reg;
        m_drop_next   = m_drop_reg;

        head_ra   = nidx(in_from);
        head_rb   = nidx(in_to);
        head_we   = 1'b0;
        head_wa   = nidx(eu_reg);
        head_wd   = {pcnt_reg[KW-1:0], 1'b0};
        pair_ra   = arc_reg[KW:1];
        pair_we   = 1'b0;
        pair_wa   = arc_reg[KW:1];
        pair_wd   = p_upd;
        level_ra  = nidx(u_reg);
        level_we  = 1'b0;
        level_wa  = nidx(u_reg);
        level_wd  = NO_LVL;
        resume_ra = nidx(u_reg);
        resume_we = 1'b0;
        resume_wa = nidx(u_reg);
        resume_wd = arc_reg;
        queue_ra  = qh_reg[NIDX-1:0];
        queue_we  = 1'b0;
        queue_wa  = qt_reg[NIDX-1:0];
        queue_wd  = v_reg;
        stack_ra  = k_reg[NIDX-1:0];
        stack_we  = 1'b0;
        stack_wa  = depth_reg[NIDX-1:0];
        stack_wd  = arc_reg[KW:0];

        case (state_reg)
            mflg_pkg::ST_LOAD: begin
                if (s_xfer) begin
                    eu_next    = in_from;
                    ev_next    = in_to;
                    ecap_next  = in_cap;
                    elast_next = s_tlast;
                    if (in_ok && ({1'b0, pcnt_reg} < (KW+2)'(MAX_EDGES))) begin
                        state_next = mflg_pkg::ST_INS1;
                    end else begin
                        if (in_ok) begin
                            ovf_next = 1'b1;
                        end
                        state_next = s_tlast ? mflg_pkg::ST_START : mflg_pkg::ST_LOAD;
                    end
                end
            end
            mflg_pkg::ST_INS1: begin
                // forward arc goes to the head of from's list, reverse to to's list
                pair_we        = 1'b1;
                pair_wa        = pcnt_reg[KW-1:0];
                pair_wd.tgt_f  = ev_reg;
                pair_wd.tgt_r  = eu_reg;
                pair_wd.link_f = head_qa_reg;
                pair_wd.link_r = (eu_reg == ev_reg) ? {1'b0, pcnt_reg[KW-1:0], 1'b0}
                                                    : head_qb_reg;
                pair_wd.res_f  = ecap_reg;
                pair_wd.res_r  = '0;
                head_we        = 1'b1;
                head_vld_next[nidx(eu_reg)] = 1'b1;
                state_next     = mflg_pkg::ST_INS2;
            end
            mflg_pkg::ST_INS2: begin
                head_we    = 1'b1;
                head_wa    = nidx(ev_reg);
                head_wd    = {pcnt_reg[KW-1:0], 1'b1};
                head_vld_next[nidx(ev_reg)] = 1'b1;
                pcnt_next  = pcnt_reg + 1'b1;
                state_next = elast_reg ? mflg_pkg::ST_START : mflg_pkg::ST_LOAD;
            end
            mflg_pkg::ST_START: begin
                flow_next = '0;
                idx_next  = '0;
                if (node_ok(src_reg, node_count_reg) && node_ok(snk_reg, node_count_reg) &&
                        (src_reg != snk_reg)) begin
                    state_next = mflg_pkg::ST_SWEEP;
                end else begin
                    state_next = mflg_pkg::ST_FINISH;
                end
            end
            mflg_pkg::ST_SWEEP: begin
                // levels to none, resume pointers to list heads, one node a cycle
                head_ra   = idx_reg[NIDX-1:0];
                resume_wa = NIDX'(idx_reg - 1'b1);
                resume_wd = head_qa_reg;
                resume_we = (idx_reg != '0);
                if (idx_reg == (NIDX+1)'(MAX_NODES)) begin
                    level_we   = 1'b1;
                    level_wa   = nidx(src_reg);
                    level_wd   = '0;
                    queue_we   = 1'b1;
                    queue_wa   = '0;
                    queue_wd   = src_reg;
                    qh_next    = '0;
                    qt_next    = (NIDX+1)'(1);
                    state_next = mflg_pkg::ST_BFS_POP;
                end else begin
                    level_we = 1'b1;
                    level_wa = idx_reg[NIDX-1:0];
                    level_wd = NO_LVL;
                    idx_next = idx_reg + 1'b1;
                end
            end
            mflg_pkg::ST_BFS_POP: begin
                if (qh_reg == qt_reg) begin
                    level_ra   = nidx(snk_reg);
                    state_next = mflg_pkg::ST_BFS_END;
                end else begin
                    qh_next    = qh_reg + 1'b1;
                    state_next = mflg_pkg::ST_BFS_U;
                end
            end
            mflg_pkg::ST_BFS_U: begin
                u_next     = queue_q_reg;
                level_ra   = nidx(queue_q_reg);
                head_ra    = nidx(queue_q_reg);
                state_next = mflg_pkg::ST_BFS_U2;
            end
            mflg_pkg::ST_BFS_U2: begin
                lvl_u_next = level_q_reg;
                arc_next   = head_qa_reg;
                state_next = mflg_pkg::ST_BFS_ARC;
            end
            mflg_pkg::ST_BFS_ARC: begin
                state_next = arc_reg[KW+1] ? mflg_pkg::ST_BFS_POP : mflg_pkg::ST_BFS_V;
            end
            mflg_pkg::ST_BFS_V: begin
                v_next      = p_tgt;
                res_nz_next = (p_res != '0);
                arc_next    = p_link;
                level_ra    = nidx(p_tgt);
                state_next  = mflg_pkg::ST_BFS_CHK;
            end
            mflg_pkg::ST_BFS_CHK: begin
                if (node_ok(v_reg, node_count_reg) && (level_q_reg == NO_LVL) && res_nz_reg) begin
                    level_we = 1'b1;
                    level_wa = nidx(v_reg);
                    level_wd = lvl_inc[LW-1:0];
                    queue_we = 1'b1;
                    qt_next  = qt_reg + 1'b1;
                end
                state_next = mflg_pkg::ST_BFS_ARC;
            end
            mflg_pkg::ST_BFS_END: begin
                if (level_q_reg != NO_LVL) begin
                    u_next     = src_reg;
                    depth_next = '0;
                    state_next = mflg_pkg::ST_DFS_TOP;
                end else begin
                    state_next = mflg_pkg::ST_FINISH;
                end
            end
            mflg_pkg::ST_DFS_TOP: begin
                if (u_reg == snk_reg) begin
                    k_next     = '0;
                    b_next     = '1;
                    state_next = mflg_pkg::ST_AUG_RD;
                end else begin
                    state_next = mflg_pkg::ST_DFS_LD;
                end
            end
            mflg_pkg::ST_DFS_LD: begin
                lvl_u_next = level_q_reg;
                arc_next   = resume_q_reg;
                state_next = mflg_pkg::ST_DFS_ARC;
            end
            mflg_pkg::ST_DFS_ARC: begin
                if (arc_reg[KW+1]) begin
                    resume_we  = 1'b1;
                    state_next = mflg_pkg::ST_DFS_RET;
                end else begin
                    state_next = mflg_pkg::ST_DFS_V;
                end
            end
            mflg_pkg::ST_DFS_V: begin
                v_next      = p_tgt;
                res_nz_next = (p_res != '0);
                link_next   = p_link;
                level_ra    = nidx(p_tgt);
                state_next  = mflg_pkg::ST_DFS_CHK;
            end
            mflg_pkg::ST_DFS_CHK: begin
                if (res_nz_reg && ({1'b0, level_q_reg} == lvl_inc)) begin
                    // advance along an admissible arc
                    resume_we  = 1'b1;
                    stack_we   = 1'b1;
                    depth_next = depth_reg + 1'b1;
                    u_next     = v_reg;
                    level_ra   = nidx(v_reg);
                    resume_ra  = nidx(v_reg);
                    state_next = mflg_pkg::ST_DFS_TOP;
                end else begin
                    arc_next   = link_reg;
                    state_next = mflg_pkg::ST_DFS_ARC;
                end
            end
            mflg_pkg::ST_DFS_RET: begin
                if (u_reg == src_reg) begin
                    idx_next   = '0;
                    state_next = mflg_pkg::ST_SWEEP;
                end else begin
                    // dead end: drop the node from the level graph and retreat
                    level_we   = 1'b1;
                    depth_next = depth_dec;
                    if (depth_dec == '0) begin
                        u_next     = src_reg;
                        state_next = mflg_pkg::ST_DFS_TOP;
                    end else begin
                        stack_ra   = NIDX'(depth_dec - 1'b1);
                        state_next = mflg_pkg::ST_PAR_S;
                    end
                end
            end
            mflg_pkg::ST_PAR_S: begin
                arc_next   = {1'b0, stack_q_reg};
                pair_ra    = stack_q_reg[KW:1];
                state_next = mflg_pkg::ST_PAR_T;
            end
            mflg_pkg::ST_PAR_T: begin
                u_next     = p_tgt;
                state_next = mflg_pkg::ST_DFS_TOP;
            end
            mflg_pkg::ST_AUG_RD: begin
                if (k_reg == depth_reg) begin
                    k_next        = '0;
                    kz_next       = '0;
                    kz_found_next = 1'b0;
                    state_next    = mflg_pkg::ST_UPD_RD;
                end else begin
                    state_next = mflg_pkg::ST_AUG_S;
                end
            end
            mflg_pkg::ST_AUG_S: begin
                arc_next   = {1'b0, stack_q_reg};
                pair_ra    = stack_q_reg[KW:1];
                state_next = mflg_pkg::ST_AUG_M;
            end
            mflg_pkg::ST_AUG_M: begin
                if (p_res < b_reg) begin
                    b_next = p_res;
                end
                k_next     = k_reg + 1'b1;
                state_next = mflg_pkg::ST_AUG_RD;
            end
            mflg_pkg::ST_UPD_RD: begin
                if (k_reg == depth_reg) begin
                    flow_next  = flow_sum[FW] ? '1 : flow_sum[FW-1:0];
                    depth_next = kz_reg;
                    if (kz_reg == '0) begin
                        u_next     = src_reg;
                        state_next = mflg_pkg::ST_DFS_TOP;
                    end else begin
                        stack_ra   = NIDX'(kz_reg - 1'b1);
                        state_next = mflg_pkg::ST_PAR_S;
                    end
                end else begin
                    state_next = mflg_pkg::ST_UPD_S;
                end
            end
            mflg_pkg::ST_UPD_S: begin
                arc_next   = {1'b0, stack_q_reg};
                pair_ra    = stack_q_reg[KW:1];
                state_next = mflg_pkg::ST_UPD_W;
            end
            mflg_pkg::ST_UPD_W: begin
                pair_we = 1'b1;
                if ((p_res == b_reg) && !kz_found_reg) begin
                    kz_next       = k_reg;
                    kz_found_next = 1'b1;
                end
                k_next     = k_reg + 1'b1;
                state_next = mflg_pkg::ST_UPD_RD;
            end
            mflg_pkg::ST_FINISH: begin
                m_flow_next   = flow_reg;
                m_drop_next   = ovf_reg;
                head_vld_next = '0;
                pcnt_next     = '0;
                ovf_next      = 1'b0;
                state_next    = mflg_pkg::ST_OUT;
            end
            mflg_pkg::ST_OUT: begin
                if (m_tready) begin
                    state_next = mflg_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = mflg_pkg::ST_LOAD;
            end
        endcase

        // the level and resume reads for the next node are issued on entry to top
        if (state_next == mflg_pkg::ST_DFS_TOP) begin
            level_ra  = nidx(u_next);
            resume_ra = nidx(u_next);
        end
        if (state_next == mflg_pkg::ST_AUG_S || state_next == mflg_pkg::ST_UPD_S) begin
            stack_ra = k_reg[NIDX-1:0];
        end
        if (state_next == mflg_pkg::ST_BFS_U) begin
            queue_ra = qh_reg[NIDX-1:0];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= mflg_pkg::ST_LOAD;
            node_count_reg <= mflg_pkg::NODE_COUNT_RST;
            src_reg        <= mflg_pkg::SOURCE_RST;
            snk_reg        <= mflg_pkg::SINK_RST;
            pcnt_reg       <= '0;
            ovf_reg        <= 1'b0;
            head_vld_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            pcnt_reg     <= pcnt_next;
            ovf_reg      <= ovf_next;
            head_vld_reg <= head_vld_next;
            if (cfg_we) begin
                case (cfg_addr)
                    mflg_pkg::CFG_NODE_COUNT: node_count_reg <= cfg_wdata;
                    mflg_pkg::CFG_SOURCE:     src_reg        <= cfg_wdata;
                    mflg_pkg::CFG_SINK:       snk_reg        <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        eu_reg       <= eu_next;
        ev_reg       <= ev_next;
        ecap_reg     <= ecap_next;
        elast_reg    <= elast_next;
        flow_reg     <= flow_next;
        idx_reg      <= idx_next;
        qh_reg       <= qh_next;
        qt_reg       <= qt_next;
        depth_reg    <= depth_next;
        k_reg        <= k_next;
        kz_reg       <= kz_next;
        kz_found_reg <= kz_found_next;
        res_nz_reg   <= res_nz_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        lvl_u_reg    <= lvl_u_next;
        arc_reg      <= arc_next;
        link_reg     <= link_next;
        b_reg        <= b_next;
        m_flow_reg   <= m_flow_next;
        m_drop_reg   <= m_drop_next;
    end

    // memories, registered reads
    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_mem[head_wa] <= head_wd;
        end
        head_qa_reg <= head_vld_reg[head_ra] ? {1'b0, head_mem[head_ra]} : PTR_NIL;
        head_qb_reg <= head_vld_reg[head_rb] ? {1'b0, head_mem[head_rb]} : PTR_NIL;
    end

    always_ff @(posedge aclk) begin
        if (pair_we) begin
            pair_mem[pair_wa] <= pair_wd;
        end
        pair_q_reg <= pair_mem[pair_ra];
    end

    always_ff @(posedge aclk) begin
        if (level_we) begin
            level_mem[level_wa] <= level_wd;
        end
        level_q_reg <= level_mem[level_ra];
    end

    always_ff @(posedge aclk) begin
        if (resume_we) begin
            resume_mem[resume_wa] <= resume_wd;
        end
        resume_q_reg <= resume_mem[resume_ra];
    end

    always_ff @(posedge aclk) begin
        if (queue_we) begin
            queue_mem[queue_wa] <= queue_wd;
        end
        queue_q_reg <= queue_mem[queue_ra];
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_wa] <= stack_wd;
        end
        stack_q_reg <= stack_mem[stack_ra];
    end

`ifndef NO_ASSERTIONS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result channels active together");

    a_store_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> (pcnt_reg == '0) && !ovf_reg && (head_vld_reg == '0))
        else $error("edge store not empty after result transfer");

    a_insert_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mflg_pkg::ST_INS1) |=> (state_reg == mflg_pkg::ST_INS2))
        else $error("arc pair insert split");

    a_store_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, pcnt_reg} <= (KW+2)'(MAX_EDGES))
        else $error("arc pair count beyond store");
`endif

endmodule

`default_nettype wire

// ===== test/max_flow_level_graph_test.sv =====
// testbench for max_flow_level_graph: loads random and directed edge sets, predicts
// the maximum flow with a behavioral Dinic solver inside a small scoreboard class
// depends on mflg_pkg and the max_flow_level_graph RTL
`default_nettype none

module max_flow_level_graph_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = 64;
    localparam int ARC_SLOTS = 2048;
    localparam logic [31:0] NIL = 32'hFFFF_FFFF;
    localparam logic [31:0] UNLIMITED = 32'd2147483647;
    localparam logic [63:0] FLOW_SAT = 64'h3FF_FFFF;

    typedef struct packed {
        logic [mflg_pkg::FLOW_W-1:0] flow;
        logic                        dropped;
    } flow_result_t;

    // behavioral max-flow solver plus queue of expected flow results
    class flow_scoreboard;
        logic [31:0] node_count, source_node, sink_node;
        logic [31:0] head[NODES];
        logic [31:0] link[ARC_SLOTS];
        logic [31:0] target[ARC_SLOTS];
        logic [31:0] resid[ARC_SLOTS];
        logic [31:0] level[NODES];
        logic [31:0] resume[NODES];
        logic [31:0] bfs_q[NODES];
        logic [31:0] stack[NODES];
        logic [31:0] arc_count;
        logic        overflow;
        flow_result_t pending_flows[$];
        int errors;

        function new();
            node_count = 32'(mflg_pkg::NODE_COUNT_RST);
            source_node = 32'(mflg_pkg::SOURCE_RST);
            sink_node = 32'(mflg_pkg::SINK_RST);
            errors = 0;
            clear_graph();
        endfunction

        function void clear_graph();
            foreach (head[i]) head[i] = NIL;
            arc_count = 0;
            overflow = 0;
        endfunction

        function void write_reg(logic [mflg_pkg::CFG_AW-1:0] idx,
                                logic [mflg_pkg::CFG_DW-1:0] val);
            case (idx)
                mflg_pkg::CFG_NODE_COUNT: node_count = 32'(val);
                mflg_pkg::CFG_SOURCE:     source_node = 32'(val);
                mflg_pkg::CFG_SINK:       sink_node = 32'(val);
                default: ;
            endcase
        endfunction

        function bit node_ok(logic [31:0] v);
            return v >= 1 && v <= node_count && v < NODES;
        endfunction

        function void put_arc(logic [31:0] u, logic [31:0] v, logic [31:0] cap);
            target[arc_count] = v;
            resid[arc_count] = cap;
            link[arc_count] = head[u];
            head[u] = arc_count;
            arc_count++;
        endfunction

        function bit build_levels();
            int qh, qt;
            logic [31:0] u, a, v;
            qh = 0;
            qt = 0;
            for (int i = 0; i < NODES; i++) begin
                level[i] = NIL;
                resume[i] = head[i];
            end
            level[source_node] = 0;
            bfs_q[qt++] = source_node;
            while (qh < qt) begin
                u = bfs_q[qh++];
                for (a = head[u]; a != NIL; a = link[a]) begin
                    v = target[a];
                    if (node_ok(v) && level[v] == NIL && resid[a] != 0) begin
                        level[v] = level[u] + 1;
                        bfs_q[qt++] = v;
                    end
                end
            end
            return level[sink_node] != NIL;
        endfunction

        function logic [63:0] blocking_flow();
            logic [63:0] total;
            logic [31:0] depth, u, a, b, v;
            int k;
            total = 0;
            depth = 0;
            u = source_node;
            forever begin
                if (u == sink_node) begin
                    b = UNLIMITED;
                    for (k = 0; k < depth; k++)
                        if (resid[stack[k]] < b) b = resid[stack[k]];
                    for (k = 0; k < depth; k++) begin
                        resid[stack[k]] -= b;
                        resid[stack[k] ^ 1] += b;
                    end
                    total += 64'(b);
                    for (k = 0; k < depth; k++)
                        if (resid[stack[k]] == 0) break;
                    depth = k;
                    u = depth != 0 ? target[stack[depth-1]] : source_node;
                    continue;
                end
                a = resume[u];
                while (a != NIL) begin
                    v = target[a];
                    if (resid[a] != 0 && level[v] == level[u] + 1) break;
                    a = link[a];
                end
                resume[u] = a;
                if (a != NIL) begin
                    stack[depth++] = a;
                    u = target[a];
                end else begin
                    if (u == source_node) break;
                    level[u] = NIL;
                    depth--;
                    u = depth != 0 ? target[stack[depth-1]] : source_node;
                end
            end
            return total;
        endfunction

        // called for every accepted edge transfer
        function void note_edge(logic [5:0] f, logic [5:0] t, logic [15:0] cap, logic last);
            logic [63:0] sum;
            flow_result_t r;
            if (f != 0 && t != 0) begin
                if (arc_count + 2 > ARC_SLOTS) begin
                    overflow = 1;
                end else begin
                    put_arc(32'(f), 32'(t), 32'(cap));
                    put_arc(32'(t), 32'(f), 32'd0);
                end
            end
            if (!last) return;
            sum = 0;
            if (node_ok(source_node) && node_ok(sink_node) && source_node != sink_node)
                while (build_levels()) sum += blocking_flow();
            r.flow = sum > FLOW_SAT ? FLOW_SAT[mflg_pkg::FLOW_W-1:0]
                                    : sum[mflg_pkg::FLOW_W-1:0];
            r.dropped = overflow;
            pending_flows.push_back(r);
            clear_graph();
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [31:0] data);
            flow_result_t want;
            if (pending_flows.size() == 0) begin
                report($sformatf("unexpected result 0x%08h", data));
                return;
            end
            want = pending_flows.pop_front();
            if (data[mflg_pkg::FLOW_W-1:0] !== want.flow)
                report($sformatf("total_flow %0d, want %0d",
                                 data[mflg_pkg::FLOW_W-1:0], want.flow));
            if (data[mflg_pkg::FLOW_W] !== want.dropped)
                report($sformatf("edges_dropped %0b, want %0b",
                                 data[mflg_pkg::FLOW_W], want.dropped));
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [mflg_pkg::CFG_AW-1:0] cfg_addr = '0;
    logic [mflg_pkg::CFG_DW-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;   // from_node [5:0], to_node [11:6], capacity [27:12], pad
    logic s_tlast = 1'b0;        // last_edge
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;        // total_flow [25:0], edges_dropped [26], pad

    int send_idle_pct = 36;
    int recv_idle_pct = 48;
    flow_scoreboard sb = new();

    max_flow_level_graph u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver backpressure, one decision per cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result transfers go straight to the scoreboard
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // write enable stays high across back-to-back writes; the caller drops it
    task write_cfg(logic [mflg_pkg::CFG_AW-1:0] idx, logic [mflg_pkg::CFG_DW-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    // block is idle only once every result is back; then a short settle pause
    task wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_flows.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task set_graph_cfg(logic [5:0] nc, logic [5:0] src, logic [5:0] snk);
        wait_drained();
        write_cfg(mflg_pkg::CFG_NODE_COUNT, nc);
        write_cfg(mflg_pkg::CFG_SOURCE, src);
        write_cfg(mflg_pkg::CFG_SINK, snk);
        cfg_we <= 1'b0;
    endtask

    // one edge transfer; valid stays high between back-to-back edges
    task send_edge(logic [5:0] f, logic [5:0] t, logic [15:0] cap, logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, cap, t, f};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_edge(f, t, cap, last);
    endtask

    function logic [5:0] pick_node(logic [5:0] nc);
        if ($urandom_range(9) == 0) return 6'($urandom_range(63));
        return 6'($urandom_range(1, (nc == 0) ? 1 : 32'(nc)));
    endfunction

    task random_graph(int n_edges);
        logic [5:0] nc, src, snk;
        logic [15:0] cap;
        case ($urandom_range(9))
            0: nc = 63;
            1: nc = 1;
            default: nc = 6'($urandom_range(2, 12));
        endcase
        src = pick_node(nc);
        snk = ($urandom_range(9) == 0) ? src : pick_node(nc);
        set_graph_cfg(nc, src, snk);
        for (int i = 0; i < n_edges; i++) begin
            cap = ($urandom_range(1) == 0) ? 16'($urandom_range(20)) : 16'($urandom);
            if ($urandom_range(3) == 0)
                send_edge(src, pick_node(nc), cap, i == n_edges - 1);
            else if ($urandom_range(3) == 0)
                send_edge(pick_node(nc), snk, cap, i == n_edges - 1);
            else
                send_edge(pick_node(nc), pick_node(nc), cap, i == n_edges - 1);
        end
    endtask

    initial begin
        int sent, n;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: parallel arcs incl. zero capacity, node zero, node 63
        send_edge(1, 26, 16'hFFFF, 0);
        send_edge(1, 26, 0, 0);
        send_edge(0, 26, 100, 0);
        send_edge(1, 0, 100, 0);
        send_edge(63, 63, 16'hFFFF, 0);
        send_edge(1, 2, 9, 0);
        send_edge(2, 26, 5, 1);
        // source equals sink
        set_graph_cfg(8, 3, 3);
        send_edge(3, 4, 50, 0);
        send_edge(4, 3, 50, 1);
        // source beyond node_count and zero source
        set_graph_cfg(4, 6, 2);
        send_edge(6, 2, 50, 1);
        set_graph_cfg(4, 0, 2);
        send_edge(1, 2, 50, 1);
        // path through a node above node_count carries nothing
        set_graph_cfg(5, 1, 5);
        send_edge(1, 9, 70, 0);
        send_edge(9, 5, 70, 0);
        send_edge(1, 5, 3, 1);
        // widest setting, reversed roles
        set_graph_cfg(63, 63, 1);
        send_edge(63, 40, 16'hFFFF, 0);
        send_edge(40, 1, 16'h8000, 0);
        send_edge(63, 1, 1, 1);
        // store overflow: edges past the arc store are dropped and flagged
        set_graph_cfg(63, 1, 2);
        send_edge(1, 2, 7, 0);
        for (int i = 0; i < 1030; i++)
            send_edge(6'($urandom_range(40, 50)), 6'($urandom_range(40, 50)),
                      16'($urandom), i == 1029);

        // random graphs over three idle regimes
        sent = 0;
        while (sent < 800) begin
            if (sent >= 533) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (sent >= 266) begin
                send_idle_pct = 48;
                recv_idle_pct = 36;
            end
            n = $urandom_range(1, 24);
            random_graph(n);
            sent += n;
        end

        wait_drained();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

`default_nettype wire

// ===== filelist.f =====
sv/mflg_pkg.sv
sv/max_flow_level_graph.sv
test/max_flow_level_graph_test.sv
